// ===== hw/rtl/csp_pkg.sv =====
// Shared types and constants for the CAN signal packer.
// Used by csp_divider, csp_frame_buf and can_signal_packer_core.
`timescale 1ns / 1ps

package csp_pkg;

   localparam int PHYS_W    = 48;
   localparam int FAC_W     = 32;
   localparam int LEN_W     = 7;
   localparam int SB_W      = 6;
   localparam int FRAME_W   = 64;
   localparam int POS_W     = 6;
   localparam int NUM_W     = PHYS_W + 2;
   localparam int QUO_W     = PHYS_W + 1;
   localparam int DIV_CNT_W = 6;
   localparam int DIV_STEPS = NUM_W;
   localparam int DELTA_INV = 10000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MIN,
      ST_MAX,
      ST_DIFF,
      ST_ABS,
      ST_NUM,
      ST_DIV,
      ST_SAT,
      ST_PLACE,
      ST_FIN
   } csp_state_type;

   typedef struct packed {
      logic             clear;
      logic             set;
      logic [POS_W-1:0] pos;
   } frame_cmd_type;

endpackage

// ===== hw/rtl/csp_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on csp_pkg for operand widths and step count.
`timescale 1ns / 1ps

module csp_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [csp_pkg::NUM_W-1:0]   numerator,
   input  logic [csp_pkg::FAC_W:0]     divisor,
   output logic                        done,
   output logic [csp_pkg::QUO_W-1:0]   quotient
);
   import csp_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FAC_W:0]       rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [FAC_W:0]       div_ff, div_in;
   logic [FAC_W+1:0]     trial;
   logic [FAC_W+1:0]     trial_diff;
   logic                 fits;
   logic                 last_step;

   assign trial      = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_diff = trial - {1'b0, div_ff};
   assign fits       = trial >= {1'b0, div_ff};
   assign last_step  = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
   assign done       = busy_ff && last_step;
   assign quotient   = quo_ff[QUO_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = numerator;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial_diff[FAC_W:0] : trial[FAC_W:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

endmodule

// ===== hw/rtl/csp_frame_buf.sv =====
// 64-bit frame buffer: cleared on command, one bit set per cycle.
// Depends on csp_pkg for the command struct.
`timescale 1ns / 1ps

module csp_frame_buf (
   input  logic                          clock,
   input  logic                          reset,
   input  csp_pkg::frame_cmd_type        cmd,
   output logic [csp_pkg::FRAME_W-1:0]   frame_data
);
   import csp_pkg::*;

   logic [FRAME_W-1:0] frame_ff, frame_in;

   always_comb begin
      frame_in = frame_ff;
      if (cmd.clear) begin
         frame_in = '0;
      end else if (cmd.set) begin
         frame_in = frame_ff | (FRAME_W'(1) << cmd.pos);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else begin
         frame_ff <= frame_in;
      end
   end

   assign frame_data = frame_ff;

endmodule

// ===== hw/rtl/can_signal_packer_core.sv =====
// Packs one CAN signal per item into a 64-bit frame: clamp, subtract offset,
// divide by the factor with rounding, saturate, then place the raw bits in
// Intel or Motorola layout. Between one accepted item and the next come the
// accepting cycle, five setup steps, the serial divider (one quotient bit
// per cycle), a saturation step, one bit placement per raw bit and a
// final step, which holds while an earlier frame still waits in the output
// register; req_ready is low from the accepting edge until the block is
// idle again. A finished frame waits in an output register, so the next
// item can be taken before it is read.
// Depends on csp_pkg, csp_divider and csp_frame_buf.
`timescale 1ns / 1ps

module can_signal_packer_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_first_signal,
   input  logic                               req_last_signal,
   input  logic [csp_pkg::SB_W-1:0]           req_start_bit,
   input  logic [csp_pkg::LEN_W-1:0]          req_signal_length,
   input  logic                               req_intel_order,
   input  logic                               req_raw_unsigned,
   input  logic signed [csp_pkg::PHYS_W-1:0]  req_physical_value,
   input  logic signed [csp_pkg::PHYS_W-1:0]  req_scale_offset,
   input  logic [csp_pkg::FAC_W-1:0]          req_scale_factor,
   input  logic signed [csp_pkg::PHYS_W-1:0]  req_phys_minimum,
   input  logic signed [csp_pkg::PHYS_W-1:0]  req_phys_maximum,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [csp_pkg::FRAME_W-1:0]        rsp_frame_data
);
   import csp_pkg::*;

   localparam logic signed [PHYS_W:0] DeltaPos =
      (PHYS_W+1)'(((64'd1 << FRAC_BITS) / DELTA_INV));
   localparam logic signed [PHYS_W:0] DeltaNeg = -DeltaPos;

   csp_state_type state_ff, state_in;

   logic                      first_ff, first_in;
   logic                      last_ff, last_in;
   logic                      intel_ff, intel_in;
   logic                      uns_ff, uns_in;
   logic [SB_W-1:0]           sb_ff, sb_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic signed [PHYS_W-1:0]  val_ff, val_in;
   logic signed [PHYS_W-1:0]  off_ff, off_in;
   logic signed [PHYS_W-1:0]  mn_ff, mn_in;
   logic signed [PHYS_W-1:0]  mx_ff, mx_in;
   logic [FAC_W-1:0]          fac_ff, fac_in;
   logic                      clamp_ff, clamp_in;
   logic signed [PHYS_W:0]    diff_ff, diff_in;
   logic                      neg_ff, neg_in;
   logic [PHYS_W-1:0]         mag_ff, mag_in;
   logic [FRAME_W-1:0]        mask_ff, mask_in;
   logic [FRAME_W-1:0]        bits_ff, bits_in;
   logic signed [5:0]         byte_ff, byte_in;
   logic [2:0]                shift_ff, shift_in;
   logic [LEN_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                      div_start;
   logic                      div_done;
   logic [NUM_W-1:0]          div_num;
   logic [QUO_W-1:0]          div_quo;
   frame_cmd_type             frame_cmd;
   logic [FRAME_W-1:0]        frame_data;

   logic signed [PHYS_W:0]    mn_wide;
   logic signed [PHYS_W:0]    mx_wide;
   logic                      clamp_on;
   logic [FRAME_W-1:0]        q_wide;
   logic [FRAME_W-1:0]        q_less;
   logic [FRAME_W-1:0]        mask_m;
   logic                      q_nz;
   logic [LEN_W-1:0]          t2;

   assign mn_wide  = (PHYS_W+1)'(mn_ff);
   assign mx_wide  = (PHYS_W+1)'(mx_ff);
   assign clamp_on = (mn_wide > DeltaPos) || (mn_wide < DeltaNeg)
                  || (mx_wide > DeltaPos) || (mx_wide < DeltaNeg);
   assign q_wide   = FRAME_W'(div_quo);
   assign q_less   = q_wide - FRAME_W'(1);
   assign mask_m   = mask_ff >> 1;
   assign q_nz     = |div_quo;
   assign t2       = LEN_W'({sb_ff[5:3], ~sb_ff[2:0]}) + len_ff - LEN_W'(1);

   assign div_start = state_ff == ST_NUM;
   assign div_num   = {1'b0, mag_ff, 1'b0} + NUM_W'(fac_ff);

   csp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (div_num),
      .divisor   ({fac_ff, 1'b0}),
      .done      (div_done),
      .quotient  (div_quo)
   );

   csp_frame_buf u_frame_buf (
      .clock      (clock),
      .reset      (reset),
      .cmd        (frame_cmd),
      .frame_data (frame_data)
   );

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      intel_in     = intel_ff;
      uns_in       = uns_ff;
      sb_in        = sb_ff;
      len_in       = len_ff;
      val_in       = val_ff;
      off_in       = off_ff;
      mn_in        = mn_ff;
      mx_in        = mx_ff;
      fac_in       = fac_ff;
      clamp_in     = clamp_ff;
      diff_in      = diff_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      mask_in      = mask_ff;
      bits_in      = bits_ff;
      byte_in      = byte_ff;
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      frame_cmd    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               first_in = req_first_signal;
               last_in  = req_last_signal;
               intel_in = req_intel_order;
               uns_in   = req_raw_unsigned;
               sb_in    = req_start_bit;
               len_in   = (req_signal_length > LEN_W'(FRAME_W)) ?
                          LEN_W'(FRAME_W) : req_signal_length;
               val_in   = req_physical_value;
               off_in   = req_scale_offset;
               mn_in    = req_phys_minimum;
               mx_in    = req_phys_maximum;
               fac_in   = (req_scale_factor == '0) ? FAC_W'(1) : req_scale_factor;
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            clamp_in = clamp_on;
            if (clamp_on && (val_ff < mn_ff)) begin
               val_in = mn_ff;
            end
            state_in = ST_MAX;
         end
         ST_MAX: begin
            if (clamp_ff && (val_ff > mx_ff)) begin
               val_in = mx_ff;
            end
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = (PHYS_W+1)'(val_ff) - (PHYS_W+1)'(off_ff);
            mask_in  = len_ff[LEN_W-1] ? '1 :
                       ((FRAME_W'(1) << len_ff[LEN_W-2:0]) - FRAME_W'(1));
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_in   = diff_ff[PHYS_W];
            mag_in   = diff_ff[PHYS_W] ? PHYS_W'(-diff_ff) : PHYS_W'(diff_ff);
            state_in = ST_NUM;
         end
         ST_NUM: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (uns_ff) begin
               if (neg_ff && q_nz) begin
                  bits_in = '0;
               end else if (|(q_wide & ~mask_ff)) begin
                  bits_in = mask_ff;
               end else begin
                  bits_in = q_wide;
               end
            end else if (!(neg_ff && q_nz)) begin
               bits_in = (|(q_wide & ~mask_m)) ? mask_m : q_wide;
            end else begin
               bits_in = (|(q_less & ~mask_m)) ? ~mask_m : (~q_wide + FRAME_W'(1));
            end
            if (intel_ff) begin
               byte_in  = 6'({3'b000, sb_ff[5:3]});
               shift_in = sb_ff[2:0];
            end else begin
               byte_in  = 6'({2'b00, t2[6:3]});
               shift_in = ~t2[2:0];
            end
            cnt_in          = len_ff;
            frame_cmd.clear = first_ff;
            state_in        = (len_ff == '0) ? ST_FIN : ST_PLACE;
         end
         ST_PLACE: begin
            frame_cmd.set = bits_ff[0] && (byte_ff[5:3] == 3'b000);
            frame_cmd.pos = {byte_ff[2:0], shift_ff};
            bits_in       = bits_ff >> 1;
            shift_in      = shift_ff + 3'd1;
            if (shift_ff == 3'd7) begin
               byte_in = intel_ff ? (byte_ff + 6'sd1) : (byte_ff - 6'sd1);
            end
            cnt_in = cnt_ff - LEN_W'(1);
            if (cnt_ff == LEN_W'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = frame_data;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      last_ff     <= last_in;
      intel_ff    <= intel_in;
      uns_ff      <= uns_in;
      sb_ff       <= sb_in;
      len_ff      <= len_in;
      val_ff      <= val_in;
      off_ff      <= off_in;
      mn_ff       <= mn_in;
      mx_ff       <= mx_in;
      fac_ff      <= fac_in;
      clamp_ff    <= clamp_in;
      diff_ff     <= diff_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      mask_ff     <= mask_in;
      bits_ff     <= bits_in;
      byte_ff     <= byte_in;
      shift_ff    <= shift_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready      = state_ff == ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_data = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in progress");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

   a_place_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLACE |-> cnt_ff != '0)
      else $error("bit placement with no bits left");

   a_frame_only_on_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> last_ff)
      else $error("frame emitted for an item without the last flag");

endmodule
